@@ hw/rtl/rd_pkg.sv @@
`timescale 1ns / 1ps
package rd_pkg;

  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic signed [32:0] PI_Q28 = 33'sd843314857;
  localparam logic [31:0] DEG_PER_RAD_Q24 = 32'd961263669;
  localparam logic signed [37:0] ONE_Q28 = 38'sd268435456;
  localparam logic signed [37:0] ONE_Q30 = 38'sd1073741824;
  localparam logic [61:0] ROUND_HALF = 62'h8_0000_0000;

  localparam logic [1:0] OUT_ZERO = 2'd0;
  localparam logic [1:0] OUT_CHORD = 2'd1;
  localparam logic [1:0] OUT_ANGLE = 2'd2;

  typedef struct packed {
    logic load_in;
    logic pair_load;
    logic mac;
    logic mac_first;
    logic [1:0] col;
    logic c_calc;
    logic h_mul;
    logic h_add;
    logic [2:0] coef_idx;
    logic sq_load;
    logic sq_angle;
    logic sq_step;
    logic r_mul;
    logic r_adj;
    logic d_mul;
    logic out_load;
    logic [1:0] out_sel;
  } rd_cmd_t;

  function automatic logic signed [31:0] acos_coef(input logic [2:0] idx);
    logic signed [31:0] c;
    case (idx)
      3'd0: c = 32'sd421657422;
      3'd1: c = -32'sd57605927;
      3'd2: c = 32'sd23885115;
      3'd3: c = -32'sd13468562;
      3'd4: c = 32'sd8292476;
      3'd5: c = -32'sd4587059;
      3'd6: c = 32'sd1790489;
      default: c = -32'sd338897;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/rd_ctrl.sv @@
`timescale 1ns / 1ps
module rd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           pair_flag,
  output rd_pkg::rd_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_CALC = 4'd2;
  localparam logic [3:0] S_HMUL = 4'd3;
  localparam logic [3:0] S_HADD = 4'd4;
  localparam logic [3:0] S_SQLD = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_RMUL = 4'd7;
  localparam logic [3:0] S_RADJ = 4'd8;
  localparam logic [3:0] S_DMUL = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] row_index, row_index_next;
  logic       metric_mode;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      row_index   <= '0;
      metric_mode <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      row_index <= row_index_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        metric_mode <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    row_index_next = row_index;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.pair_load = (row_index != 2'd1) && (row_index != 2'd2);
          cnt_next      = '0;
          state_next    = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac       = 1'b1;
        cmd.col       = cnt[1:0];
        cmd.mac_first = (row_index != 2'd1) && (row_index != 2'd2) && (cnt == 5'd0);
        cnt_next      = cnt + 5'd1;
        if (cnt == 5'd2) begin
          if (row_index == 2'd2) begin
            row_index_next = 2'd0;
            if (!pair_flag) begin
              state_next = S_FIN;
            end else if (metric_mode) begin
              state_next = S_CALC;
            end else begin
              state_next = S_SQLD;
            end
          end else if (row_index == 2'd1) begin
            row_index_next = 2'd2;
            state_next     = S_IDLE;
          end else begin
            row_index_next = 2'd1;
            state_next     = S_IDLE;
          end
        end
      end
      S_CALC: begin
        cmd.c_calc = 1'b1;
        cnt_next   = 5'd6;
        state_next = S_HMUL;
      end
      S_HMUL: begin
        cmd.h_mul  = 1'b1;
        state_next = S_HADD;
      end
      S_HADD: begin
        cmd.h_add    = 1'b1;
        cmd.coef_idx = cnt[2:0];
        if (cnt == 5'd0) begin
          state_next = S_SQLD;
        end else begin
          cnt_next   = cnt - 5'd1;
          state_next = S_HMUL;
        end
      end
      S_SQLD: begin
        cmd.sq_load  = 1'b1;
        cmd.sq_angle = metric_mode;
        cnt_next     = '0;
        state_next   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 5'd1;
        if (cnt == 5'd31) begin
          state_next = metric_mode ? S_RMUL : S_FIN;
        end
      end
      S_RMUL: begin
        cmd.r_mul  = 1'b1;
        state_next = S_RADJ;
      end
      S_RADJ: begin
        cmd.r_adj  = 1'b1;
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.d_mul  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.out_sel = !pair_flag ? rd_pkg::OUT_ZERO :
                      (metric_mode ? rd_pkg::OUT_ANGLE : rd_pkg::OUT_CHORD);
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_index != 2'd3)
    else $error("row index out of range");

  a_third_row_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && cnt == 5'd2 && row_index == 2'd2) |=> !in_ready)
    else $error("input taken before result formed");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
`endif

endmodule

@@ hw/rtl/rd_datapath.sv @@
`timescale 1ns / 1ps
module rd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  rd_pkg::rd_cmd_t        cmd,
  input  logic signed [15:0]     obs_col0,
  input  logic signed [15:0]     obs_col1,
  input  logic signed [15:0]     obs_col2,
  input  logic signed [15:0]     fit_col0,
  input  logic signed [15:0]     fit_col1,
  input  logic signed [15:0]     fit_col2,
  input  logic                   pair_present,
  output logic                   pair_flag,
  output logic [23:0]            distance
);

  logic signed [15:0] obs0, obs1, obs2, fit0, fit1, fit2;
  logic               pair_in;
  logic signed [35:0] product_sum;
  logic [37:0]        squared_diff_sum;
  logic [30:0]        u;
  logic               neg;
  logic signed [31:0] p;
  logic               psign;
  logic [61:0]        mulreg;
  logic [31:0]        rad;
  logic [63:0]        sv;
  logic [31:0]        root;
  logic [33:0]        rem;

  logic signed [15:0] o, f;
  logic signed [31:0] prod;
  logic signed [16:0] diff;
  logic signed [33:0] sqv;
  logic signed [37:0] c, cl;
  logic [31:0]        pmag, ma, mb;
  logic [31:0]        t;
  logic signed [32:0] r;
  logic [35:0]        rem2, trial;
  logic [61:0]        dsum;
  logic [25:0]        deg;

  always_comb begin
    case (cmd.col)
      2'd0: begin
        o = obs0;
        f = fit0;
      end
      2'd1: begin
        o = obs1;
        f = fit1;
      end
      default: begin
        o = obs2;
        f = fit2;
      end
    endcase
    prod = o * f;
    diff = 17'(o) - 17'(f);
    sqv  = diff * diff;

    c  = (38'(product_sum) - rd_pkg::ONE_Q28) <<< 1;
    cl = c;
    if (c > rd_pkg::ONE_Q30) begin
      cl = rd_pkg::ONE_Q30;
    end else if (c < -rd_pkg::ONE_Q30) begin
      cl = -rd_pkg::ONE_Q30;
    end

    pmag = p[31] ? 32'(-p) : 32'(p);
    ma   = cmd.d_mul ? rad : pmag;
    if (cmd.h_mul) begin
      mb = {1'b0, u};
    end else if (cmd.r_mul) begin
      mb = root;
    end else begin
      mb = rd_pkg::DEG_PER_RAD_Q24;
    end

    t = mulreg[61:30];
    r = psign ? -$signed({1'b0, t}) : $signed({1'b0, t});
    if (neg) begin
      r = rd_pkg::PI_Q28 - r;
    end

    rem2  = {rem, sv[63:62]};
    trial = {2'b00, root, 2'b01};

    dsum = mulreg + rd_pkg::ROUND_HALF;
    deg  = dsum[61:36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_flag <= 1'b0;
    end else if (cmd.mac && cmd.mac_first) begin
      pair_flag <= pair_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      obs0 <= obs_col0;
      obs1 <= obs_col1;
      obs2 <= obs_col2;
      fit0 <= fit_col0;
      fit1 <= fit_col1;
      fit2 <= fit_col2;
      if (cmd.pair_load) begin
        pair_in <= pair_present;
      end
    end
    if (cmd.mac) begin
      product_sum      <= (cmd.mac_first ? 36'sd0 : product_sum) + 36'(prod);
      squared_diff_sum <= (cmd.mac_first ? 38'd0 : squared_diff_sum)
                          + 38'($unsigned(sqv));
    end
    if (cmd.c_calc) begin
      neg <= cl < 0;
      u   <= cl < 0 ? 31'(-cl) : 31'(cl);
      p   <= rd_pkg::acos_coef(3'd7);
    end
    if (cmd.h_mul || cmd.r_mul || cmd.d_mul) begin
      mulreg <= 62'({32'd0, ma} * {32'd0, mb});
    end
    if (cmd.h_mul || cmd.r_mul) begin
      psign <= p[31];
    end
    if (cmd.h_add) begin
      p <= (psign ? -$signed(t) : $signed(t)) + rd_pkg::acos_coef(cmd.coef_idx);
    end
    if (cmd.r_adj) begin
      rad <= (r < 0) ? 32'd0 : r[31:0];
    end
    if (cmd.sq_load) begin
      sv   <= cmd.sq_angle ? {3'b000, 31'h4000_0000 - u, 30'd0}
                           : {22'd0, squared_diff_sum, 4'd0};
      root <= '0;
      rem  <= '0;
    end else if (cmd.sq_step) begin
      sv <= {sv[61:0], 2'b00};
      if (rem2 >= trial) begin
        rem  <= 34'(rem2 - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem2[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        rd_pkg::OUT_CHORD: distance <= (root > 32'(rd_pkg::DIST_MAX)) ?
                                       rd_pkg::DIST_MAX : root[23:0];
        rd_pkg::OUT_ANGLE: distance <= (deg > 26'(rd_pkg::DIST_MAX)) ?
                                       rd_pkg::DIST_MAX : deg[23:0];
        default:           distance <= '0;
      endcase
    end
  end

endmodule

@@ hw/rtl/rotation_distance.sv @@
`timescale 1ns / 1ps
// three transactions (rows 0..2) form one comparison; rows 0 and 1 give no result
// rows 0 and 1: an accept plus three multiply-accumulate steps each
// row 2: chordal mode runs the 32-step square root; axis-angle mode first runs the
// 7-step polynomial, then the square root and the radian and degree scaling
// a finished result waits in the output register while the next row is accepted
// synchronous reset clears the row count, metric mode (chordal) and out_valid
module rotation_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] obs_col0,
  input  logic signed [15:0] obs_col1,
  input  logic signed [15:0] obs_col2,
  input  logic signed [15:0] fit_col0,
  input  logic signed [15:0] fit_col1,
  input  logic signed [15:0] fit_col2,
  input  logic               pair_present,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        distance,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  rd_pkg::rd_cmd_t cmd;
  logic            pair_flag;

  rd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pair_flag (pair_flag),
    .cmd       (cmd)
  );

  rd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .obs_col0     (obs_col0),
    .obs_col1     (obs_col1),
    .obs_col2     (obs_col2),
    .fit_col0     (fit_col0),
    .fit_col1     (fit_col1),
    .fit_col2     (fit_col2),
    .pair_present (pair_present),
    .pair_flag    (pair_flag),
    .distance     (distance)
  );

endmodule
